>>> rtl/img2x_pkg.sv
// shared types, constants and kernel helpers for the 2x bicubic/bilinear upscaler
// no dependencies; imported by every module of the block
package img2x_pkg;

   localparam int COORD_W    = 9;      // column and row fields
   localparam int DIM_W      = 13;     // source dimensions up to 4096
   localparam int ELEV_W     = 16;
   localparam int HARD_W     = 13;
   localparam int ELEV_OUT_W = 17;
   localparam int WT_W       = 8;      // one axis weight, over 128
   localparam int PW_W       = 15;     // product of two axis weights
   localparam int ACC_W      = 32;
   localparam int FRAC_BITS  = 14;
   localparam int ROUND_BIAS = 8192;
   localparam int HARD_FULL  = 4096;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int DIM_RESET  = 256;
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic {
      FILTER_BILINEAR = 1'b0,
      FILTER_BICUBIC  = 1'b1
   } filter_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_HARD_EN    = 2'd2,
      REG_FILTER     = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   // keys kernel (a = -0.5) at quarter offsets, reversed for odd outputs
   function automatic logic signed [WT_W-1:0] axis_weight(logic cubic, logic odd,
                                                          logic [1:0] i);
      logic [1:0] j;
      logic signed [WT_W-1:0] w;
      j = odd ? ~i : i;
      w = '0;
      if (cubic) begin
         case (j)
            2'd0:    w = -8'sd3;
            2'd1:    w = 8'sd29;
            2'd2:    w = 8'sd111;
            2'd3:    w = -8'sd9;
            default: w = '0;
         endcase
      end else begin
         // bilinear uses two taps; reversal maps tap 0/1 onto codes 3/2
         case (j)
            2'd0, 2'd2: w = 8'sd32;
            2'd1, 2'd3: w = 8'sd96;
            default:    w = '0;
         endcase
      end
      return w;
   endfunction

   // source tap index along one axis, clamped to the edge
   function automatic logic [DIM_W-1:0] axis_tap(logic [COORD_W-1:0] o,
                                                 logic [DIM_W-1:0] n,
                                                 logic cubic, logic [1:0] i);
      logic [1:0] off;
      logic signed [DIM_W+1:0] p;
      logic signed [DIM_W+1:0] lim;
      logic [DIM_W-1:0] r;
      off = cubic ? (o[0] ? 2'd1 : 2'd2) : (o[0] ? 2'd0 : 2'd1);
      p = $signed((DIM_W+2)'(o[COORD_W-1:1])) - $signed((DIM_W+2)'(off))
          + $signed((DIM_W+2)'(i));
      lim = $signed((DIM_W+2)'(n - DIM_W'(1)));
      if (p[DIM_W+1]) r = '0;
      else if (p > lim) r = lim[DIM_W-1:0];
      else r = p[DIM_W-1:0];
      return r;
   endfunction

endpackage

>>> rtl/image_upscale_2x_bicubic_bilinear_unit.sv
// a bicubic read sweeps 16 taps, a bilinear read 4; the sum drains through the store read,
// product and accumulator registers to the finish step; an out-of-grid read goes to finish
// throughput: a write every cycle; after a read no request is taken until the finish
// step writes the result, and finish waits on a held result; the taps come one per
// cycle from the single-port source store into one shared multiply-accumulate unit
// reset: control, handshake and configuration registers return to defaults; store contents
// are undefined until written, there is no clearing pass
module image_upscale_2x_bicubic_bilinear_unit import img2x_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [COORD_W-1:0]           req_column,
   input  logic [COORD_W-1:0]           req_row,
   input  logic signed [ELEV_W-1:0]     req_elevation_in,
   input  logic [HARD_W-1:0]            req_hardness_in,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ELEV_OUT_W-1:0] rsp_elevation_out,
   output logic [HARD_W-1:0]            rsp_hardness_out,
   output logic                         rsp_error,
   // configuration writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // control
   state_type state_in, state_ff;
   logic [1:0] tap_x_in, tap_x_ff;          // column tap counter
   logic [1:0] tap_y_in, tap_y_ff;          // row tap counter
   logic issue_v_in, issue_v_ff;            // store read in flight
   logic rsp_valid_in, rsp_valid_ff;
   // configuration
   logic [COORD_W-1:0] src_width_in, src_width_ff;
   logic [COORD_W-1:0] src_height_in, src_height_ff;
   logic hard_en_in, hard_en_ff;
   logic filter_in, filter_ff;
   // payload
   logic [COORD_W-1:0] col_in, col_ff;
   logic [COORD_W-1:0] row_in, row_ff;
   logic err_in, err_ff;
   logic signed [PW_W-1:0] wt_in, wt_ff;
   logic signed [ELEV_OUT_W-1:0] rsp_elev_in, rsp_elev_ff;
   logic [HARD_W-1:0] rsp_hard_in, rsp_hard_ff;
   logic rsp_err_in, rsp_err_ff;

   // datapath wires
   logic [DIM_W-1:0] w_eff, h_eff;
   logic cubic;
   logic [1:0] last_tap;
   logic accept, wr_in_range, off_grid;
   logic [DIM_W-1:0] x_src, y_src;
   logic [AW-1:0] tap_addr, wr_addr, store_addr;
   logic store_we;
   logic signed [2*WT_W-1:0] wt_full;
   logic signed [ELEV_W-1:0] rd_elevation;
   logic [HARD_W-1:0] rd_hardness;
   mac_ctl_type mac_ctl;
   logic signed [ACC_W-1:0] acc_e, acc_h, rnd_e, rnd_h;
   logic signed [ACC_W-FRAC_BITS-1:0] hv;
   logic [HARD_W-1:0] hard_clamped;
   logic mac_busy;

   // effective source size: zero counts as one, saturate at the store size
   always_comb begin
      w_eff = DIM_W'(src_width_ff);
      if (src_width_ff == '0) w_eff = DIM_W'(1);
      else if (DIM_W'(src_width_ff) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      h_eff = DIM_W'(src_height_ff);
      if (src_height_ff == '0) h_eff = DIM_W'(1);
      else if (DIM_W'(src_height_ff) > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
   end

   assign cubic    = (filter_ff == FILTER_BICUBIC);
   assign last_tap = cubic ? 2'd3 : 2'd1;

   // request handshake: only idle takes a request
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign wr_in_range = (DIM_W'(req_column) < DIM_W'(MAX_WIDTH)) &&
                        (DIM_W'(req_row) < DIM_W'(MAX_HEIGHT));
   assign off_grid = ((DIM_W+1)'(req_column) >= {w_eff, 1'b0}) ||
                     ((DIM_W+1)'(req_row) >= {h_eff, 1'b0});

   // tap address generation, edge-clamped per axis
   assign x_src    = axis_tap(col_ff, w_eff, cubic, tap_x_ff);
   assign y_src    = axis_tap(row_ff, h_eff, cubic, tap_y_ff);
   assign tap_addr = AW'(y_src) * AW'(MAX_WIDTH) + AW'(x_src);
   assign wr_addr  = AW'(req_row) * AW'(MAX_WIDTH) + AW'(req_column);

   // store port: writes only while idle, tap reads while running
   assign store_we   = accept && (req_operation == OP_WRITE) && wr_in_range;
   assign store_addr = (state_ff == ST_IDLE) ? wr_addr : tap_addr;

   // weight of the tap, lined up with the registered store read
   assign wt_full = axis_weight(cubic, col_ff[0], tap_x_ff) *
                    axis_weight(cubic, row_ff[0], tap_y_ff);

   img2x_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock        (clock),
      .write_enable (store_we),
      .address      (store_addr),
      .wr_elevation (req_elevation_in),
      .wr_hardness  (req_hardness_in),
      .rd_elevation (rd_elevation),
      .rd_hardness  (rd_hardness)
   );

   assign mac_ctl.clear = accept && (req_operation == OP_READ);
   assign mac_ctl.valid = issue_v_ff;

   img2x_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .ctl           (mac_ctl),
      .elevation     (rd_elevation),
      .hardness      (rd_hardness),
      .weight        (wt_ff),
      .acc_elevation (acc_e),
      .acc_hardness  (acc_h),
      .busy          (mac_busy)
   );

   // round half up at 2^-14, then clamp hardness between zero and full scale
   assign rnd_e = acc_e + ACC_W'(ROUND_BIAS);
   assign rnd_h = acc_h + ACC_W'(ROUND_BIAS);
   assign hv    = rnd_h[ACC_W-1:FRAC_BITS];

   always_comb begin
      if (hv[ACC_W-FRAC_BITS-1]) hard_clamped = '0;
      else if (hv > (ACC_W-FRAC_BITS)'(HARD_FULL)) hard_clamped = HARD_W'(HARD_FULL);
      else hard_clamped = hv[HARD_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tap_x_in      = tap_x_ff;
      tap_y_in      = tap_y_ff;
      issue_v_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      hard_en_in    = hard_en_ff;
      filter_in     = filter_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      err_in        = err_ff;
      wt_in         = wt_full[PW_W-1:0];
      rsp_elev_in   = rsp_elev_ff;
      rsp_hard_in   = rsp_hard_ff;
      rsp_err_in    = rsp_err_ff;

      if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            REG_SRC_WIDTH:  src_width_in  = csr_data;
            REG_SRC_HEIGHT: src_height_in = csr_data;
            REG_HARD_EN:    hard_en_in    = csr_data[0];
            REG_FILTER:     filter_in     = csr_data[0];
            default:        ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_READ)) begin
               col_in   = req_column;
               row_in   = req_row;
               tap_x_in = '0;
               tap_y_in = '0;
               err_in   = off_grid;
               state_in = off_grid ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            // one tap read issued per cycle, column fastest
            issue_v_in = 1'b1;
            if (tap_x_ff == last_tap) begin
               tap_x_in = '0;
               tap_y_in = tap_y_ff + 2'd1;
               if (tap_y_ff == last_tap) state_in = ST_DRAIN;
            end else begin
               tap_x_in = tap_x_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (!issue_v_ff && !mac_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               if (err_ff) begin
                  rsp_elev_in = '0;
                  rsp_hard_in = '0;
               end else begin
                  rsp_elev_in = rnd_e[FRAC_BITS +: ELEV_OUT_W];
                  rsp_hard_in = hard_en_ff ? hard_clamped : HARD_W'(HARD_FULL);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_x_ff      <= '0;
         tap_y_ff      <= '0;
         issue_v_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= COORD_W'(DIM_RESET);
         src_height_ff <= COORD_W'(DIM_RESET);
         hard_en_ff    <= 1'b1;
         filter_ff     <= FILTER_BICUBIC;
      end else begin
         state_ff      <= state_in;
         tap_x_ff      <= tap_x_in;
         tap_y_ff      <= tap_y_in;
         issue_v_ff    <= issue_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         hard_en_ff    <= hard_en_in;
         filter_ff     <= filter_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      err_ff      <= err_in;
      wt_ff       <= wt_in;
      rsp_elev_ff <= rsp_elev_in;
      rsp_hard_ff <= rsp_hard_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elevation_out = rsp_elev_ff;
   assign rsp_hardness_out  = rsp_hard_ff;
   assign rsp_error         = rsp_err_ff;

`ifndef SYNTHESIS
   // an off-grid result carries zero payload
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_elevation_out == '0 && rsp_hardness_out == '0)
      else $error("error result with nonzero payload");

   // hardness never exceeds full scale
   a_hard_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hardness_out <= HARD_W'(HARD_FULL))
      else $error("hardness above full scale");

   // disabled hardness gives full scale on good results
   a_hard_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error && !hard_en_ff |-> rsp_hardness_out == HARD_W'(HARD_FULL))
      else $error("hardness not full scale while disabled");

   // store reads reach the accumulator only from the tap sweep
   a_issue_src: assert property (@(posedge clock) disable iff (reset)
      issue_v_ff |-> $past(state_ff == ST_RUN))
      else $error("tap read outside of sweep");
`endif

endmodule

>>> rtl/img2x_store.sv
// source frame store: elevation and hardness arrays, one port, registered read
// depends on img2x_pkg
module img2x_store import img2x_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
   parameter int AW    = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [AW-1:0]            address,
   input  logic signed [ELEV_W-1:0] wr_elevation,
   input  logic [HARD_W-1:0]        wr_hardness,
   output logic signed [ELEV_W-1:0] rd_elevation,
   output logic [HARD_W-1:0]        rd_hardness
);

   logic signed [ELEV_W-1:0] elev_mem [DEPTH];
   logic [HARD_W-1:0]        hard_mem [DEPTH];
   logic signed [ELEV_W-1:0] rd_elevation_ff;
   logic [HARD_W-1:0]        rd_hardness_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         elev_mem[address] <= wr_elevation;
         hard_mem[address] <= wr_hardness;
      end
      rd_elevation_ff <= elev_mem[address];
      rd_hardness_ff  <= hard_mem[address];
   end

   assign rd_elevation = rd_elevation_ff;
   assign rd_hardness  = rd_hardness_ff;

endmodule

>>> rtl/img2x_mac.sv
// shared multiply-accumulate unit, one tap per cycle for elevation and hardness
// depends on img2x_pkg
module img2x_mac import img2x_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctl_type              ctl,
   input  logic signed [ELEV_W-1:0] elevation,
   input  logic [HARD_W-1:0]        hardness,
   input  logic signed [PW_W-1:0]   weight,
   output logic signed [ACC_W-1:0]  acc_elevation,
   output logic signed [ACC_W-1:0]  acc_hardness,
   output logic                     busy
);

   logic signed [ELEV_W+PW_W-1:0]   prod_e_in, prod_e_ff;
   logic signed [HARD_W+PW_W:0]     prod_h_in, prod_h_ff;
   logic                            pvalid_in, pvalid_ff;
   logic signed [ACC_W-1:0]         acc_e_in, acc_e_ff;
   logic signed [ACC_W-1:0]         acc_h_in, acc_h_ff;

   always_comb begin
      prod_e_in = elevation * weight;
      prod_h_in = $signed({1'b0, hardness}) * weight;
      pvalid_in = ctl.valid;
      acc_e_in  = acc_e_ff;
      acc_h_in  = acc_h_ff;
      if (ctl.clear) begin
         acc_e_in = '0;
         acc_h_in = '0;
      end else if (pvalid_ff) begin
         acc_e_in = acc_e_ff + ACC_W'(prod_e_ff);
         acc_h_in = acc_h_ff + ACC_W'(prod_h_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
      end
      prod_e_ff <= prod_e_in;
      prod_h_ff <= prod_h_in;
      acc_e_ff  <= acc_e_in;
      acc_h_ff  <= acc_h_in;
   end

   assign acc_elevation = acc_e_ff;
   assign acc_hardness  = acc_h_ff;
   assign busy          = pvalid_ff;

endmodule

>>> sim/image_upscale_2x_bicubic_bilinear_unit_test.sv
// self-checking bench for the 2x bicubic/bilinear upscaler: directed table, then random phases
// predicts every read not typed into the opening script from its own copy of the source store
// needs the rtl package and the block with its store and multiply-accumulate modules
module image_upscale_2x_bicubic_bilinear_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import img2x_pkg::*;

   localparam int STORE_W         = MAX_WIDTH_DEF;
   localparam int STORE_H         = MAX_HEIGHT_DEF;
   localparam int SETTLE_CYCLES   = 32;        // quiet time after every owed pixel is back
   localparam int LONG_HOLD       = 400;
   localparam int LIMIT           = 1000000;
   localparam int ITEMS_PER_PHASE = 50;        // neighborhood loads come on top
   localparam int NUM_PHASES      = 6;
   localparam int NUM_OPEN        = 26;
   localparam int MAX_REPORTS     = 60;

   typedef struct packed {
      op_type             op;
      logic [8:0]         col;
      logic [8:0]         row;
      logic signed [15:0] elev;
      logic [12:0]        hard;
   } pixel_request;

   typedef struct packed {
      logic signed [16:0] elev;
      logic [12:0]        hard;
      logic               err;
   } pixel_result;

   // one line of the opening script: a register write or a request,
   // with the answer typed in where it is obvious
   typedef struct {
      bit           is_reg;
      csr_idx_type  reg_idx;
      logic [8:0]   reg_val;
      pixel_request req;
      bit           preset;
      pixel_result  want;
   } script_row;

   // settings per random phase: tiny, wide strip, tall strip, odd sizes,
   // full store with saturated width, 2x2
   localparam logic [8:0] PHASE_WIDTH  [NUM_PHASES] = '{9'd4, 9'd256, 9'd0, 9'd7, 9'd300, 9'd2};
   localparam logic [8:0] PHASE_HEIGHT [NUM_PHASES] = '{9'd3, 9'd1, 9'd511, 9'd5, 9'd256, 9'd2};
   localparam bit         PHASE_HARD   [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam filter_type PHASE_FILTER [NUM_PHASES] = '{FILTER_BICUBIC, FILTER_BILINEAR,
      FILTER_BICUBIC, FILTER_BILINEAR, FILTER_BICUBIC, FILTER_BILINEAR};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_operation;
   logic [COORD_W-1:0]           req_column;
   logic [COORD_W-1:0]           req_row;
   logic signed [ELEV_W-1:0]     req_elevation_in;
   logic [HARD_W-1:0]            req_hardness_in;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [ELEV_OUT_W-1:0] rsp_elevation_out;
   logic [HARD_W-1:0]            rsp_hardness_out;
   logic                         rsp_error;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   // shadow of the block: source store, which entries hold data, and the registers
   logic signed [15:0] src_elev    [STORE_W*STORE_H];
   logic [12:0]        src_hard    [STORE_W*STORE_H];
   bit                 src_written [STORE_W*STORE_H];
   logic [8:0]         cfg_width   = 9'd256;
   logic [8:0]         cfg_height  = 9'd256;
   logic               cfg_hard_en = 1'b1;
   filter_type         cfg_filter  = FILTER_BICUBIC;

   pixel_result pending_pixels[$];   // upscaled pixels still owed by the block
   int          fail_count  = 0;
   int          hold_cycles = 0;     // set by the stimulus, counted down by the receiver
   int          send_idle_pct;
   int          recv_idle_pct;
   int unsigned cycle_count = 0;

   image_upscale_2x_bicubic_bilinear_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_elevation_in  (req_elevation_in),
      .req_hardness_in   (req_hardness_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_elevation_out (rsp_elevation_out),
      .rsp_hardness_out  (rsp_hardness_out),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // a dimension of 0 acts as 1, anything past the store saturates
   function automatic int span_of(logic [8:0] v, int max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return v;
   endfunction

   // source index of tap i for output coordinate o, clamped to the edge
   function automatic int source_tap(int o, int n, bit cubic, int i);
      int k;
      int first;
      int p;
      k = o / 2;
      if (cubic) first = (o % 2) ? k - 1 : k - 2;
      else first = (o % 2) ? k : k - 1;
      p = first + i;
      if (p < 0) p = 0;
      if (p > n - 1) p = n - 1;
      return p;
   endfunction

   // keys kernel at quarter offsets, or the 1/4 : 3/4 split, over 128
   function automatic int tap_weight(bit cubic, bit odd, int i);
      int j;
      if (!cubic) return (odd ? (i == 0) : (i == 1)) ? 96 : 32;
      j = odd ? 3 - i : i;
      case (j)
         0: return -3;
         1: return 29;
         2: return 111;
         default: return -9;
      endcase
   endfunction

   function automatic pixel_result upscale_pixel(int col, int row);
      pixel_result res;
      int          w, h, taps, a, b, x, y, wt;
      bit          cubic;
      longint      esum, hsum, ev, hv;
      res   = '0;
      esum  = 0;
      hsum  = 0;
      w     = span_of(cfg_width, STORE_W);
      h     = span_of(cfg_height, STORE_H);
      cubic = (cfg_filter == FILTER_BICUBIC);
      if (col >= 2 * w || row >= 2 * h) begin
         res.err = 1'b1;
         return res;
      end
      taps = cubic ? 4 : 2;
      for (b = 0; b < taps; b++) begin
         for (a = 0; a < taps; a++) begin
            x  = source_tap(col, w, cubic, a);
            y  = source_tap(row, h, cubic, b);
            wt = tap_weight(cubic, bit'(col % 2), a) * tap_weight(cubic, bit'(row % 2), b);
            esum += longint'(wt) * longint'(src_elev[y*STORE_W+x]);
            hsum += longint'(wt) * longint'(src_hard[y*STORE_W+x]);
         end
      end
      // round half up at 2^-14, floor division by arithmetic shift
      ev = (esum + ROUND_BIAS) >>> FRAC_BITS;
      hv = (hsum + ROUND_BIAS) >>> FRAC_BITS;
      if (hv < 0) hv = 0;
      if (hv > HARD_FULL) hv = HARD_FULL;
      if (!cfg_hard_en) hv = HARD_FULL;
      res.elev = ev[16:0];
      res.hard = hv[12:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus values

   function automatic logic signed [15:0] fresh_elev();
      if ($urandom_range(99) < 10) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      return 16'($urandom);
   endfunction

   // mostly legal hardness, now and then above full scale
   function automatic logic [12:0] fresh_hard();
      if ($urandom_range(99) < 80) return 13'($urandom_range(HARD_FULL));
      return 13'($urandom_range(8191));
   endfunction

   function automatic pixel_request random_store(int w, int h);
      pixel_request q;
      q.op = OP_WRITE;
      if ($urandom_range(99) < 70) begin
         q.col = 9'($urandom_range(w - 1));
         q.row = 9'($urandom_range(h - 1));
      end else begin
         // anywhere in the field: past the active size, or past the store and dropped
         q.col = 9'($urandom);
         q.row = 9'($urandom);
      end
      q.elev = fresh_elev();
      q.hard = fresh_hard();
      return q;
   endfunction

   // a read past the doubled grid on at least one axis
   function automatic pixel_request stray_read(int w, int h);
      pixel_request q;
      q      = '0;
      q.op   = OP_READ;
      q.col  = 9'($urandom_range(511));
      q.row  = 9'($urandom_range(511));
      if (2 * w < 512 && (2 * h >= 512 || $urandom_range(1))) q.col = 9'($urandom_range(511, 2 * w));
      else q.row = 9'($urandom_range(511, 2 * h));
      return q;
   endfunction

   // output coordinate biased to the edges, and to a small window on big grids
   // so that the neighborhoods to load stay few
   function automatic int pick_coord(int span);
      int e;
      e = $urandom_range(3);
      if (e > span - 1) e = span - 1;
      if ($urandom_range(99) < 30) return $urandom_range(1) ? e : span - 1 - e;
      if (span > 48 && $urandom_range(99) < 70) return $urandom_range(35, 20);
      return $urandom_range(span - 1);
   endfunction

   // ---------------------------------------------------------------- opening script rows

   function automatic script_row blank_row();
      script_row s;
      s.is_reg  = 1'b0;
      s.reg_idx = REG_SRC_WIDTH;
      s.reg_val = '0;
      s.req     = '0;
      s.req.op  = OP_WRITE;
      s.preset  = 1'b0;
      s.want    = '0;
      return s;
   endfunction

   function automatic script_row store_row(int c, int r, int e, int h);
      script_row s;
      s          = blank_row();
      s.req.col  = 9'(c);
      s.req.row  = 9'(r);
      s.req.elev = 16'(e);
      s.req.hard = 13'(h);
      return s;
   endfunction

   function automatic script_row fetch_row(int c, int r);
      script_row s;
      s         = blank_row();
      s.req.op  = OP_READ;
      s.req.col = 9'(c);
      s.req.row = 9'(r);
      return s;
   endfunction

   function automatic script_row fetch_known(int c, int r, int e, int h, bit err);
      script_row s;
      s           = fetch_row(c, r);
      s.preset    = 1'b1;
      s.want.elev = 17'(e);
      s.want.hard = 13'(h);
      s.want.err  = err;
      return s;
   endfunction

   function automatic script_row reg_row(csr_idx_type idx, int v);
      script_row s;
      s         = blank_row();
      s.is_reg  = 1'b1;
      s.reg_idx = idx;
      s.reg_val = 9'(v);
      return s;
   endfunction

   // ---------------------------------------------------------------- drivers

   // present one request, hold it until taken, then update the shadow
   task automatic offer_request(input pixel_request r, input bit preset,
                                input pixel_result known);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = r.op;
      req_column       = r.col;
      req_row          = r.row;
      req_elevation_in = r.elev;
      req_hardness_in  = r.hard;
      do @(posedge clock); while (req_stall);
      if (r.op == OP_WRITE) begin
         // writes outside the store are dropped by the block
         if (r.col < STORE_W && r.row < STORE_H) begin
            src_elev[r.row*STORE_W+r.col]    = r.elev;
            src_hard[r.row*STORE_W+r.col]    = r.hard;
            src_written[r.row*STORE_W+r.col] = 1'b1;
         end
      end else begin
         pending_pixels.push_back(preset ? known : upscale_pixel(r.col, r.row));
      end
   endtask

   // load any tap of the neighborhood not yet written, then ask for the pixel
   task automatic request_pixel(input int col, input int row);
      pixel_request q;
      int           w, h, taps, a, b, x, y;
      bit           cubic;
      w     = span_of(cfg_width, STORE_W);
      h     = span_of(cfg_height, STORE_H);
      cubic = (cfg_filter == FILTER_BICUBIC);
      taps  = cubic ? 4 : 2;
      if (col < 2 * w && row < 2 * h) begin
         for (b = 0; b < taps; b++) begin
            for (a = 0; a < taps; a++) begin
               x = source_tap(col, w, cubic, a);
               y = source_tap(row, h, cubic, b);
               if (!src_written[y*STORE_W+x]) begin
                  q.op   = OP_WRITE;
                  q.col  = 9'(x);
                  q.row  = 9'(y);
                  q.elev = fresh_elev();
                  q.hard = fresh_hard();
                  offer_request(q, 1'b0, '0);
               end
            end
         end
      end
      q      = '0;
      q.op   = OP_READ;
      q.col  = 9'(col);
      q.row  = 9'(row);
      offer_request(q, 1'b0, '0);
   endtask

   task automatic await_results();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // drop valid, let every owed pixel come back, then let the pipe go quiet
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [8:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SRC_WIDTH:  cfg_width   = val;
         REG_SRC_HEIGHT: cfg_height  = val;
         REG_HARD_EN:    cfg_hard_en = val[0];
         REG_FILTER:     cfg_filter  = filter_type'(val[0]);
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- receiver

   // random stall, or a long hold-off when the stimulus asks for one
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall   = 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : check_results
      pixel_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: result with nothing pending: elevation %0d hardness %0d error %0b",
                        $time, rsp_elevation_out, rsp_hardness_out, rsp_error);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_elevation_out !== want.elev) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: elevation mismatch, expected %0d, got %0d",
                           $time, want.elev, rsp_elevation_out);
            end
            if (rsp_hardness_out !== want.hard) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: hardness mismatch, expected %0d, got %0d",
                           $time, want.hard, rsp_hardness_out);
            end
            if (rsp_error !== want.err) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: error flag mismatch, expected %0b, got %0b",
                           $time, want.err, rsp_error);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("image_upscale_2x_bicubic_bilinear_unit_test: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      script_row opening [NUM_OPEN];
      int        i, ph, n, r, w, h;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_WRITE;
      req_column       = '0;
      req_row          = '0;
      req_elevation_in = '0;
      req_hardness_in  = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_SRC_WIDTH;
      csr_data         = '0;
      send_idle_pct    = 13;
      recv_idle_pct    = 85;

      // opening script under reset settings (256 x 256, bicubic, hardness on);
      // a uniform 2x2 corner must come back unchanged at output (0,0)
      opening = '{
         // full-scale corner, hardness above full scale must clamp
         store_row(0, 0, 32767, 8191),
         store_row(1, 0, 32767, 8191),
         store_row(0, 1, 32767, 8191),
         store_row(1, 1, 32767, 8191),
         // writes past the store are dropped, they must not alias onto the corner
         store_row(256, 0, -1, 0),
         store_row(0, 256, -1, 0),
         store_row(511, 511, -1, 0),
         fetch_known(0, 0, 32767, HARD_FULL, 1'b0),
         // most negative corner, zero hardness
         store_row(0, 0, -32768, 0),
         store_row(1, 0, -32768, 0),
         store_row(0, 1, -32768, 0),
         store_row(1, 1, -32768, 0),
         fetch_known(0, 0, -32768, 0, 1'b0),
         // hardness off gives full scale
         reg_row(REG_HARD_EN, 0),
         fetch_known(0, 0, -32768, HARD_FULL, 1'b0),
         reg_row(REG_FILTER, FILTER_BILINEAR),
         store_row(1, 1, 12345, 100),
         fetch_row(1, 1),
         // zero width acts as one column; out-of-grid reads on each axis
         reg_row(REG_SRC_WIDTH, 0),
         reg_row(REG_SRC_HEIGHT, 2),
         fetch_known(2, 0, 0, 0, 1'b1),
         fetch_known(0, 4, 0, 0, 1'b1),
         fetch_row(1, 3),
         reg_row(REG_HARD_EN, 1),
         reg_row(REG_FILTER, FILTER_BICUBIC),
         fetch_row(1, 2)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < NUM_OPEN; i++) begin
         if (opening[i].is_reg) begin
            quiesce();
            write_reg(opening[i].reg_idx, opening[i].reg_val);
            @(negedge clock);
            csr_valid = 1'b0;
         end else begin
            offer_request(opening[i].req, opening[i].preset, opening[i].want);
         end
      end

      // random phases: slow receiver, then slow sender, then full rate
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         quiesce();
         if (ph < 2) begin
            send_idle_pct = 13;
            recv_idle_pct = 85;
         end else if (ph < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_reg(REG_SRC_WIDTH, PHASE_WIDTH[ph]);
         write_reg(REG_SRC_HEIGHT, PHASE_HEIGHT[ph]);
         // single-bit registers get junk in the upper bits
         write_reg(REG_HARD_EN, {8'($urandom), PHASE_HARD[ph]});
         write_reg(REG_FILTER, {8'($urandom), logic'(PHASE_FILTER[ph])});
         @(negedge clock);
         csr_valid = 1'b0;
         w = span_of(cfg_width, STORE_W);
         h = span_of(cfg_height, STORE_H);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while requests keep coming: the block backs up
            if (ph == 4 && n == 10) hold_cycles = LONG_HOLD;
            // sender waits for every owed pixel once, mid-phase
            if (ph == 1 && n == ITEMS_PER_PHASE / 2) begin
               @(negedge clock);
               req_valid = 1'b0;
               await_results();
            end
            r = $urandom_range(99);
            if (r < 25) offer_request(random_store(w, h), 1'b0, '0);
            else if (r < 33 && (2 * w < 512 || 2 * h < 512))
               offer_request(stray_read(w, h), 1'b0, '0);
            else request_pixel(pick_coord(2 * w), pick_coord(2 * h));
         end
      end

      quiesce();
      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("image_upscale_2x_bicubic_bilinear_unit_test: done, clean");
      else
         $display("image_upscale_2x_bicubic_bilinear_unit_test: done, errors");
      $finish;
   end

endmodule
